// ===== hdl/fvrgb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fvrgb_pkg
// Shared constants and tables for the flow vector color coder.
// ----------------------------------------------------------------------------
package fvrgb_pkg;

    localparam int CORDIC_GUARD = 16;
    localparam logic [29:0] INV_GAIN = 30'd652032875;
    localparam logic [16:0] AMP_ONE = 17'd65536;

    function automatic logic [31:0] atan_turn(input int idx);
        logic [31:0] t;
        case (idx % 32)
            0: t = 32'h20000000;  1: t = 32'h12E4051E;  2: t = 32'h09FB385B;
            3: t = 32'h051111D4;  4: t = 32'h028B0D43;  5: t = 32'h0145D7E1;
            6: t = 32'h00A2F61E;  7: t = 32'h00517C55;  8: t = 32'h0028BE53;
            9: t = 32'h00145F2F;  10: t = 32'h000A2F98; 11: t = 32'h000517CC;
            12: t = 32'h00028BE6; 13: t = 32'h000145F3; 14: t = 32'h0000A2FA;
            15: t = 32'h0000517D; 16: t = 32'h000028BE; 17: t = 32'h0000145F;
            18: t = 32'h00000A30; 19: t = 32'h00000518; 20: t = 32'h0000028C;
            21: t = 32'h00000146; 22: t = 32'h000000A3; 23: t = 32'h00000051;
            24: t = 32'h00000029; 25: t = 32'h00000014; 26: t = 32'h0000000A;
            27: t = 32'h00000005; 28: t = 32'h00000003; 29: t = 32'h00000001;
            30: t = 32'h00000001;
            default: t = 32'h00000000;
        endcase
        return t;
    endfunction

    // segment end colors: {r0, g0, b0, r1, g1, b1}
    function automatic logic [7:0] seg_color(input logic [2:0] seg, input logic [2:0] k);
        logic [47:0] row;
        case (seg)
            3'd0: row = {8'd255, 8'd0, 8'd0, 8'd255, 8'd0, 8'd255};
            3'd1: row = {8'd255, 8'd0, 8'd255, 8'd64, 8'd64, 8'd255};
            3'd2: row = {8'd64, 8'd64, 8'd255, 8'd0, 8'd255, 8'd255};
            3'd3: row = {8'd0, 8'd255, 8'd255, 8'd0, 8'd255, 8'd0};
            3'd4: row = {8'd0, 8'd255, 8'd0, 8'd255, 8'd255, 8'd0};
            default: row = {8'd255, 8'd255, 8'd0, 8'd255, 8'd0, 8'd0};
        endcase
        return row[8'(47 - 8 * k) -: 8];
    endfunction

endpackage

// ===== hdl/flow_vector_to_rgb_color.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flow_vector_to_rgb_color
// Color-wheel coding of a flow vector: CORDIC angle and magnitude, six-segment
// color interpolation, magnitude scaling.
// ----------------------------------------------------------------------------
// channel  direction  signals
// in       input      in_valid, in_ready, flow_x, flow_y
// out      output     out_valid, out_ready, red, green, blue
//
// One item per cycle while the output is not stalled. CORDIC_STAGES + 5
// register stages: one prep stage, one stage per CORDIC iteration, then
// magnitude, gain multiply, color mix and output scaling stages. The whole
// pipeline advances together; when the output is stalled every stage holds.
// Reset clears the valid bits only.
module flow_vector_to_rgb_color
    import fvrgb_pkg::*;
#(
    parameter int COORD_WIDTH   = 16,
    parameter int FRACTION_BITS = 12,
    parameter int CORDIC_STAGES = 16
)(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [COORD_WIDTH-1:0] flow_x,
    input  logic signed [COORD_WIDTH-1:0] flow_y,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [7:0]                    red,
    output logic [7:0]                    green,
    output logic [7:0]                    blue
);
    localparam int CW = COORD_WIDTH + CORDIC_GUARD + 3;
    localparam int SH = FRACTION_BITS + CORDIC_GUARD - 16;
    localparam int NS = CORDIC_STAGES + 5;

    logic advance;
    logic [NS-1:0] vld_reg;
    assign advance = out_ready | ~vld_reg[NS-1];
    assign in_ready = advance;
    assign out_valid = vld_reg[NS-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (advance)
            vld_reg <= {vld_reg[NS-2:0], in_valid};
    end

    // CORDIC state per stage 0..CORDIC_STAGES
    logic signed [CW-1:0] cx_reg [CORDIC_STAGES+1];
    logic signed [CW-1:0] cy_reg [CORDIC_STAGES+1];
    logic [31:0] ca_reg [CORDIC_STAGES+1];
    logic axis_reg [CORDIC_STAGES+1];   // axis override flag
    logic [31:0] aa_reg [CORDIC_STAGES+1];

    logic signed [CW-1:0] px, py;
    logic [31:0] pa, oa;
    logic ov;
    always_comb
    begin
        px = CW'(flow_x) <<< CORDIC_GUARD;
        py = CW'(flow_y) <<< CORDIC_GUARD;
        pa = 32'h0;
        if (flow_x < 0)
        begin
            px = -px;
            py = -py;
            pa = 32'h80000000;
        end
        ov = 1'b1;
        if (flow_x == 0)
            oa = (flow_y >= 0) ? 32'h40000000 : 32'hC0000000;
        else if (flow_y == 0)
            oa = (flow_x > 0) ? 32'h0 : 32'h80000000;
        else
        begin
            oa = 32'h0;
            ov = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            cx_reg[0] <= px;
            cy_reg[0] <= py;
            ca_reg[0] <= pa;
            axis_reg[0] <= ov;
            aa_reg[0] <= oa;
        end
    end

    for (genvar i = 0; i < CORDIC_STAGES; i++)
    begin : g_cordic
        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                if (cy_reg[i] >= 0)
                begin
                    cx_reg[i+1] <= cx_reg[i] + (cy_reg[i] >>> (i % 32));
                    cy_reg[i+1] <= cy_reg[i] - (cx_reg[i] >>> (i % 32));
                    ca_reg[i+1] <= ca_reg[i] + atan_turn(i);
                end
                else
                begin
                    cx_reg[i+1] <= cx_reg[i] - (cy_reg[i] >>> (i % 32));
                    cy_reg[i+1] <= cy_reg[i] + (cx_reg[i] >>> (i % 32));
                    ca_reg[i+1] <= ca_reg[i] - atan_turn(i);
                end
                axis_reg[i+1] <= axis_reg[i];
                aa_reg[i+1] <= aa_reg[i];
            end
        end
    end

    // magnitude clamp and final angle
    logic signed [CW-1:0] fx;
    logic [CW-1:0] fa;
    logic [18:0] mag_next, mag_reg;
    logic [31:0] ang_next, ang_reg, ang2_reg;
    always_comb
    begin
        fx = cx_reg[CORDIC_STAGES];
        fa = (fx >= 0) ? CW'(fx >>> SH) : '0;
        mag_next = (fa > CW'(1 << 18)) ? 19'(1 << 18) : fa[18:0];
        ang_next = axis_reg[CORDIC_STAGES] ? aa_reg[CORDIC_STAGES]
                                           : ca_reg[CORDIC_STAGES];
    end

    logic [48:0] prod_reg;
    logic [16:0] amp_next, amp_reg;
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            mag_reg <= mag_next;
            ang_reg <= ang_next;
            prod_reg <= mag_reg * INV_GAIN;
            ang2_reg <= ang_reg;
            amp_reg <= amp_next;
        end
    end
    always_comb
        amp_next = (prod_reg[48:30] > 19'(AMP_ONE)) ? AMP_ONE : prod_reg[46:30];

    // color mix
    logic [2:0] oct, seg;
    logic [15:0] beta;
    logic signed [25:0] cmix [3];
    logic [24:0] c_next [3], c_reg [3];
    always_comb
    begin
        oct = ang2_reg[31:29];
        case (oct)
            3'd0, 3'd1, 3'd2, 3'd3: seg = oct;
            3'd4, 3'd5: seg = 3'd4;
            default: seg = 3'd5;
        endcase
        if (!oct[2])
            beta = ang2_reg[28:13];
        else
            beta = ang2_reg[29:14];
        for (int k = 0; k < 3; k++)
        begin
            cmix[k] = $signed({2'b0, seg_color(seg, 3'(k)), 16'h0})
                + $signed({1'b0, beta}) * ($signed({1'b0, seg_color(seg, 3'(k + 3))})
                - $signed({1'b0, seg_color(seg, 3'(k))}));
            c_next[k] = cmix[k][25] ? '0 : cmix[k][24:0];
        end
    end

    logic [41:0] v [3];
    logic [7:0] o_reg [3];
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int k = 0; k < 3; k++)
            begin
                c_reg[k] <= c_next[k];
                o_reg[k] <= (v[k][41:32] > 10'd255) ? 8'd255 : v[k][39:32];
            end
        end
    end
    always_comb
        for (int k = 0; k < 3; k++)
            v[k] = amp_reg * c_reg[k];

    assign red = o_reg[0];
    assign green = o_reg[1];
    assign blue = o_reg[2];

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(red) && $stable(green)
            && $stable(blue))
        else $error("stalled output changed");
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("pipeline stalled while empty at output");
    a_known: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !$isunknown({red, green, blue}))
        else $error("unknown color on valid output");
endmodule
